// File: rtl/core/btop_pkg.sv
// Shared types, codes and arithmetic helpers for the binomial tree option pricer.
// Used by btop_regs, btop_ctrl, btop_dp and binomial_tree_option_pricer_core.
`default_nettype none
package btop_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_STEP_COUNT  = 3'd0;
    localparam logic [2:0] REG_IS_CALL     = 3'd1;
    localparam logic [2:0] REG_IS_AMERICAN = 3'd2;
    localparam logic [2:0] REG_STRIKE      = 3'd3;
    localparam logic [2:0] REG_UP_WEIGHT   = 3'd4;
    localparam logic [2:0] REG_DOWN_WEIGHT = 3'd5;
    localparam logic [2:0] REG_UP_FACTOR   = 3'd6;
    localparam logic [2:0] REG_DOWN_FACTOR = 3'd7;

    localparam logic [31:0] UP_FACTOR_RST = 32'h1000_0000;

    typedef struct packed {
        logic [10:0] step_count;
        logic        is_call;
        logic        is_american;
        logic [31:0] strike;
        logic [31:0] up_weight;
        logic [31:0] down_weight;
        logic [31:0] up_factor;
        logic [31:0] down_factor;
    } cfg_t;

    // datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DOWN,
        OP_BUILD_W,
        OP_BUILD_M1,
        OP_BUILD_M2,
        OP_READ,
        OP_ROW_LOAD,
        OP_NODE_MUL,
        OP_NODE_WR,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOWN,
        ST_BUILD_W,
        ST_BUILD_M1,
        ST_BUILD_M2,
        ST_ROW_START,
        ST_ROW_LOAD,
        ST_NODE_RD,
        ST_NODE_MUL,
        ST_NODE_WR,
        ST_FINISH
    } state_t;

    // price times d, Q0.32, round half up
    function automatic logic [31:0] mul_down(input logic [31:0] a, input logic [31:0] d);
        logic [63:0] pr;
        pr = 64'(a) * 64'(d) + 64'h0000_0000_8000_0000;
        return pr[63:32];
    endfunction

    // price times u, Q4.28, round half up, saturated
    function automatic logic [31:0] mul_up(input logic [31:0] a, input logic [31:0] u);
        logic [63:0] pr;
        pr = 64'(a) * 64'(u) + 64'h0000_0000_0800_0000;
        return (|pr[63:60]) ? 32'hFFFF_FFFF : pr[59:28];
    endfunction

    function automatic logic [31:0] payoff(input logic [31:0] price, input logic [31:0] k,
                                           input logic call);
        logic [31:0] r;
        r = 32'd0;
        if (call) begin
            if (price > k) r = price - k;
        end else begin
            if (k > price) r = k - price;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/btop_regs.sv
// APB configuration register file for the option pricer.
// Depends on btop_pkg for register indexes and the cfg_t bundle.
`default_nettype none
module btop_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output btop_pkg::cfg_t     cfg
);
    btop_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_count  <= 11'd1;
            cfg_reg.is_call     <= 1'b1;
            cfg_reg.is_american <= 1'b0;
            cfg_reg.strike      <= '0;
            cfg_reg.up_weight   <= '0;
            cfg_reg.down_weight <= '0;
            cfg_reg.up_factor   <= btop_pkg::UP_FACTOR_RST;
            cfg_reg.down_factor <= '0;
        end else if (wr_en) begin
            unique case (idx)
                btop_pkg::REG_STEP_COUNT:  cfg_reg.step_count  <= pwdata[10:0];
                btop_pkg::REG_IS_CALL:     cfg_reg.is_call     <= pwdata[0];
                btop_pkg::REG_IS_AMERICAN: cfg_reg.is_american <= pwdata[0];
                btop_pkg::REG_STRIKE:      cfg_reg.strike      <= pwdata;
                btop_pkg::REG_UP_WEIGHT:   cfg_reg.up_weight   <= pwdata;
                btop_pkg::REG_DOWN_WEIGHT: cfg_reg.down_weight <= pwdata;
                btop_pkg::REG_UP_FACTOR:   cfg_reg.up_factor   <= pwdata;
                btop_pkg::REG_DOWN_FACTOR: cfg_reg.down_factor <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            btop_pkg::REG_STEP_COUNT:  prdata = {21'd0, cfg_reg.step_count};
            btop_pkg::REG_IS_CALL:     prdata = {31'd0, cfg_reg.is_call};
            btop_pkg::REG_IS_AMERICAN: prdata = {31'd0, cfg_reg.is_american};
            btop_pkg::REG_STRIKE:      prdata = cfg_reg.strike;
            btop_pkg::REG_UP_WEIGHT:   prdata = cfg_reg.up_weight;
            btop_pkg::REG_DOWN_WEIGHT: prdata = cfg_reg.down_weight;
            btop_pkg::REG_UP_FACTOR:   prdata = cfg_reg.up_factor;
            btop_pkg::REG_DOWN_FACTOR: prdata = cfg_reg.down_factor;
            default:                   prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/core/btop_ctrl.sv
// Sequencer for the option pricer: walks the down steps, the terminal build
// and the backward induction rows. Depends on btop_pkg.
`default_nettype none
module btop_ctrl #(
    parameter int MAX_STEPS = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [10:0]       step_count,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              out_full,
    input  wire logic              m_tready,
    output btop_pkg::dp_op_t       op,
    output logic [$clog2(MAX_STEPS+1)-1:0] addr
);
    localparam int CW = $clog2(MAX_STEPS + 1);

    btop_pkg::state_t state_reg, state_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] n_eff;

    // effective step count: zero runs one step, large values clamp
    always_comb begin
        if (step_count == 11'd0)
            n_eff = CW'(1);
        else if (32'(step_count) > 32'(MAX_STEPS))
            n_eff = CW'(MAX_STEPS);
        else
            n_eff = CW'(step_count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= btop_pkg::ST_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
        end
    end

    // next state and counters
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        unique case (state_reg)
            btop_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = btop_pkg::ST_DOWN;
                    k_next     = '0;
                end
            end
            btop_pkg::ST_DOWN: begin
                k_next = k_reg + CW'(1);
                if (k_reg == n_eff - CW'(1)) begin
                    state_next = btop_pkg::ST_BUILD_W;
                    j_next     = '0;
                end
            end
            btop_pkg::ST_BUILD_W: begin
                if (j_reg == n_eff) begin
                    state_next = btop_pkg::ST_ROW_START;
                    i_next     = n_eff - CW'(1);
                end else begin
                    state_next = btop_pkg::ST_BUILD_M1;
                end
            end
            btop_pkg::ST_BUILD_M1: state_next = btop_pkg::ST_BUILD_M2;
            btop_pkg::ST_BUILD_M2: begin
                state_next = btop_pkg::ST_BUILD_W;
                j_next     = j_reg + CW'(1);
            end
            btop_pkg::ST_ROW_START: begin
                state_next = btop_pkg::ST_ROW_LOAD;
                j_next     = '0;
            end
            btop_pkg::ST_ROW_LOAD: state_next = btop_pkg::ST_NODE_RD;
            btop_pkg::ST_NODE_RD:  state_next = btop_pkg::ST_NODE_MUL;
            btop_pkg::ST_NODE_MUL: state_next = btop_pkg::ST_NODE_WR;
            btop_pkg::ST_NODE_WR: begin
                if (j_reg == i_reg) begin
                    if (i_reg == '0) begin
                        state_next = btop_pkg::ST_FINISH;
                    end else begin
                        state_next = btop_pkg::ST_ROW_START;
                        i_next     = i_reg - CW'(1);
                    end
                end else begin
                    state_next = btop_pkg::ST_NODE_RD;
                    j_next     = j_reg + CW'(1);
                end
            end
            btop_pkg::ST_FINISH: begin
                if (!out_full || m_tready) state_next = btop_pkg::ST_IDLE;
            end
            default: state_next = btop_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        op       = btop_pkg::OP_NONE;
        addr     = j_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            btop_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) op = btop_pkg::OP_LOAD;
            end
            btop_pkg::ST_DOWN:      op = btop_pkg::OP_DOWN;
            btop_pkg::ST_BUILD_W:   op = btop_pkg::OP_BUILD_W;
            btop_pkg::ST_BUILD_M1:  op = btop_pkg::OP_BUILD_M1;
            btop_pkg::ST_BUILD_M2:  op = btop_pkg::OP_BUILD_M2;
            btop_pkg::ST_ROW_START: begin
                op   = btop_pkg::OP_READ;
                addr = '0;
            end
            btop_pkg::ST_ROW_LOAD:  op = btop_pkg::OP_ROW_LOAD;
            btop_pkg::ST_NODE_RD: begin
                op   = btop_pkg::OP_READ;
                addr = j_reg + CW'(1);
            end
            btop_pkg::ST_NODE_MUL:  op = btop_pkg::OP_NODE_MUL;
            btop_pkg::ST_NODE_WR:   op = btop_pkg::OP_NODE_WR;
            btop_pkg::ST_FINISH: begin
                if (!out_full || m_tready) op = btop_pkg::OP_OUT;
            end
            default: op = btop_pkg::OP_NONE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/core/btop_dp.sv
// Datapath for the option pricer: node value and price memories, the
// multipliers, payoff and output register. Depends on btop_pkg.
`default_nettype none
module btop_dp #(
    parameter int MAX_STEPS = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire btop_pkg::cfg_t                cfg,
    input  wire btop_pkg::dp_op_t              op,
    input  wire logic [$clog2(MAX_STEPS+1)-1:0] addr,
    input  wire logic [31:0]                   spot,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [31:0]                        m_tdata
);
    localparam int DEPTH = MAX_STEPS + 1;

    logic [31:0] val_mem [DEPTH];
    logic [31:0] price_mem [DEPTH];

    logic [31:0] p_reg, t_reg, lo_reg, hi_reg, pd_reg, vrd_reg, prd_reg, res_reg;
    logic [63:0] t1_reg, t2_reg;
    logic [31:0] out_reg;
    logic        out_vld_reg;

    logic [64:0] wsum;
    logic [31:0] cont, ex, node_val;

    // weighted sum, round half up, saturate
    always_comb begin
        wsum     = 65'(t1_reg) + 65'(t2_reg) + 65'h0_0000_0000_8000_0000;
        cont     = wsum[64] ? 32'hFFFF_FFFF : wsum[63:32];
        ex       = btop_pkg::payoff(pd_reg, cfg.strike, cfg.is_call);
        node_val = (cfg.is_american && (ex > cont)) ? ex : cont;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (op == btop_pkg::OP_BUILD_W) begin
            price_mem[addr] <= p_reg;
            val_mem[addr]   <= btop_pkg::payoff(p_reg, cfg.strike, cfg.is_call);
        end else if (op == btop_pkg::OP_NODE_WR) begin
            val_mem[addr] <= node_val;
            if (cfg.is_american) price_mem[addr] <= pd_reg;
        end
        if (op == btop_pkg::OP_READ) begin
            vrd_reg <= val_mem[addr];
            prd_reg <= price_mem[addr];
        end
    end

    // arithmetic registers
    always_ff @(posedge aclk) begin
        unique case (op)
            btop_pkg::OP_LOAD:     p_reg <= spot;
            btop_pkg::OP_DOWN:     p_reg <= btop_pkg::mul_down(p_reg, cfg.down_factor);
            btop_pkg::OP_BUILD_M1: t_reg <= btop_pkg::mul_up(p_reg, cfg.up_factor);
            btop_pkg::OP_BUILD_M2: p_reg <= btop_pkg::mul_up(t_reg, cfg.up_factor);
            btop_pkg::OP_ROW_LOAD: lo_reg <= vrd_reg;
            btop_pkg::OP_NODE_MUL: begin
                hi_reg <= vrd_reg;
                t1_reg <= 64'(vrd_reg) * 64'(cfg.up_weight);
                t2_reg <= 64'(lo_reg) * 64'(cfg.down_weight);
                pd_reg <= btop_pkg::mul_down(prd_reg, cfg.down_factor);
            end
            btop_pkg::OP_NODE_WR: begin
                lo_reg  <= hi_reg;
                res_reg <= node_val;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (op == btop_pkg::OP_OUT) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
        if (op == btop_pkg::OP_OUT) out_reg <= res_reg;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;
endmodule
`default_nettype wire

// File: rtl/core/binomial_tree_option_pricer_core.sv
// Cox-Ross-Rubinstein binomial option pricer, top level.
// Usage:
//  s_ channel: one spot price request per item (tdata = spot_price, Q16.16).
//  m_ channel: one option value per item (tdata = option_value, Q16.16).
//  APB port configures step count n, call/put, American mode, strike,
//  discounted weights and the up/down factors; write only while idle.
// Sequence for n effective steps (zero runs one step, above MAX_STEPS clamps):
//  the accept step, the spot scaled by d once per step, the terminal build (two
//  multiplies per node through one price register), then per row i (i+1
//  nodes) a row start and row load, then one node at a time through a
//  single-port memory pair and a multiply stage, then the output register load.
//  One item is in work at a time; s_tready is high only while idle.
// Reset clears the controller and the output valid flag and loads the
//  register reset values; node memories are not cleared.
// When the receiver stalls the finished result waits in the output
//  register; a following item is accepted and computed, and only its own
//  result waits until the output register frees.
`default_nettype none
module binomial_tree_option_pricer_core #(
    parameter int MAX_STEPS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] spot_price
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] option_value
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CW = $clog2(MAX_STEPS + 1);

    btop_pkg::cfg_t   cfg;
    btop_pkg::dp_op_t op;
    logic [CW-1:0]    addr;

    btop_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    btop_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_count (cfg.step_count),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .out_full   (m_tvalid),
        .m_tready   (m_tready),
        .op         (op),
        .addr       (addr)
    );

    btop_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .op       (op),
        .addr     (addr),
        .spot     (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );
endmodule
`default_nettype wire
